// ----- sv/etot_pkg.sv -----
// Shared types, constants and microcode program for the totient counter.
// No dependencies.
package etot_pkg;

    localparam int VALUE_BITS = 16;
    localparam int STEP_BITS  = 4;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [STEP_BITS-1:0]  step_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INIT_GCD,
        OP_SHIFT_A,
        OP_SHIFT_B,
        OP_SUB,
        OP_COUNT,
        OP_NEXT_I,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_I_GE_N,
        C_BOTH_EVEN,
        C_A_EVEN,
        C_B_EVEN,
        C_A_EQ_B,
        C_A_IS_ONE,
        C_OUT_BLOCKED
    } cond_t;

    // op runs every cycle unless guard is set, then only when the test hits;
    // jump to target on a hit, else fall through
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  neg;
        logic  guard;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic i_ge_n;
        logic both_even;
        logic a_even;
        logic b_even;
        logic a_eq_b;
        logic a_is_one;
        logic out_blocked;
    } flags_t;

    typedef struct packed {
        op_t  op;
        logic exec;
        logic idle;
    } ctrl_t;

    localparam step_t S_IDLE   = step_t'(0);
    localparam step_t S_TEST_I = step_t'(1);
    localparam step_t S_SHA    = step_t'(4);
    localparam step_t S_SHB    = step_t'(5);
    localparam step_t S_SUB    = step_t'(6);
    localparam step_t S_NEXT   = step_t'(8);
    localparam step_t S_WAIT   = step_t'(9);
    localparam step_t S_OUT    = step_t'(10);

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, neg: 1'b0, guard: 1'b0, target: S_IDLE};
        case (step)
            S_IDLE:   w = '{OP_NOP,      C_IN_VALID,    1'b1, 1'b0, S_IDLE};
            S_TEST_I: w = '{OP_NOP,      C_I_GE_N,      1'b0, 1'b0, S_WAIT};
            4'd2:     w = '{OP_INIT_GCD, C_ALWAYS,      1'b1, 1'b0, S_IDLE};
            4'd3:     w = '{OP_NOP,      C_BOTH_EVEN,   1'b0, 1'b0, S_NEXT};
            S_SHA:    w = '{OP_SHIFT_A,  C_A_EVEN,      1'b0, 1'b1, S_SHA};
            S_SHB:    w = '{OP_SHIFT_B,  C_B_EVEN,      1'b0, 1'b1, S_SHB};
            S_SUB:    w = '{OP_SUB,      C_A_EQ_B,      1'b1, 1'b1, S_SHA};
            4'd7:     w = '{OP_COUNT,    C_A_IS_ONE,    1'b0, 1'b1, S_NEXT};
            S_NEXT:   w = '{OP_NEXT_I,   C_ALWAYS,      1'b0, 1'b0, S_TEST_I};
            S_WAIT:   w = '{OP_NOP,      C_OUT_BLOCKED, 1'b0, 1'b0, S_WAIT};
            S_OUT:    w = '{OP_OUT,      C_ALWAYS,      1'b0, 1'b0, S_IDLE};
            default:  w = '{OP_NOP,      C_ALWAYS,      1'b0, 1'b0, S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/euler_totient_count_core.sv -----
// Channel  Valid      Stall      Payload
// input    in_valid   in_stall   n        (16 b unsigned)
// output   out_valid  out_stall  totient  (16 b unsigned)
//
// One beat in, one beat out. Each i in 2..n-1 runs a binary GCD against n
// on a single shift/subtract datapath; each GCD pass shifts a and b right
// while even, then subtracts the smaller from the larger. Input is taken
// only at the sequencer's idle step; a waiting result does not block the
// next input beat. Reset clears the step counter and out_valid.
// Depends on etot_pkg and etot_seq.
module euler_totient_count_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  etot_pkg::value_t n,
    output logic             out_valid,
    input  logic             out_stall,
    output etot_pkg::value_t totient
);
    import etot_pkg::*;

    flags_t flags;
    ctrl_t  ctrl;

    value_t n_reg;
    value_t i_reg;
    value_t a_reg;
    value_t b_reg;
    value_t cnt_reg;
    value_t totient_reg;
    logic   out_valid_reg;
    logic   accept;
    logic   run;

    etot_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign accept    = ctrl.idle && in_valid;
    assign run       = ctrl.exec;
    assign in_stall  = !ctrl.idle;
    assign out_valid = out_valid_reg;
    assign totient   = totient_reg;

    always_comb
    begin
        flags.in_valid    = in_valid;
        flags.i_ge_n      = (i_reg >= n_reg);
        flags.both_even   = !a_reg[0] && !b_reg[0];
        flags.a_even      = !a_reg[0];
        flags.b_even      = !b_reg[0];
        flags.a_eq_b      = (a_reg == b_reg);
        flags.a_is_one    = (a_reg == value_t'(1));
        flags.out_blocked = out_valid_reg && out_stall;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg   <= n;
            i_reg   <= value_t'(2);
            cnt_reg <= value_t'(1);
        end
        else if (run)
        begin
            case (ctrl.op)
                OP_INIT_GCD:
                begin
                    a_reg <= n_reg;
                    b_reg <= i_reg;
                end
                OP_SHIFT_A: a_reg <= a_reg >> 1;
                OP_SHIFT_B: b_reg <= b_reg >> 1;
                OP_SUB:
                begin
                    if (a_reg > b_reg)
                        a_reg <= a_reg - b_reg;
                    else
                        b_reg <= b_reg - a_reg;
                end
                OP_COUNT:   cnt_reg <= cnt_reg + value_t'(1);
                OP_NEXT_I:  i_reg <= i_reg + value_t'(1);
                OP_OUT:     totient_reg <= cnt_reg;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (run && ctrl.op == OP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    a_sub_unequal: assert property (@(posedge clk) disable iff (!rst_n)
        (run && ctrl.op == OP_SUB) |-> (a_reg != b_reg))
        else $error("subtract step with equal operands");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !ctrl.idle)
        else $error("sequencer stayed idle after accepting a beat");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (run && ctrl.op == OP_OUT) |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a held output beat");

endmodule

// ----- sv/etot_seq.sv -----
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on etot_pkg.
module etot_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  etot_pkg::flags_t flags,
    output etot_pkg::ctrl_t  ctrl
);
    import etot_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   test;
    logic   hit;

    always_comb
    begin
        word = ucode_rom(step_reg);
        case (word.cond)
            C_ALWAYS:      test = 1'b1;
            C_IN_VALID:    test = flags.in_valid;
            C_I_GE_N:      test = flags.i_ge_n;
            C_BOTH_EVEN:   test = flags.both_even;
            C_A_EVEN:      test = flags.a_even;
            C_B_EVEN:      test = flags.b_even;
            C_A_EQ_B:      test = flags.a_eq_b;
            C_A_IS_ONE:    test = flags.a_is_one;
            C_OUT_BLOCKED: test = flags.out_blocked;
            default:       test = 1'b0;
        endcase
        hit       = test ^ word.neg;
        step_next = hit ? word.target : step_reg + step_t'(1);
        ctrl.op   = word.op;
        ctrl.exec = word.guard ? hit : 1'b1;
        ctrl.idle = (step_reg == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
